FILE: src/ip6tp_pkg.sv
`timescale 1ns / 1ps
package ip6tp_pkg;

  localparam int DEFAULT_MAX_TEXT_LEN = 64;
  localparam int GROUPS = 8;
  localparam int GROUP_DIGITS_MAX = 4;
  localparam int GROUP_W = 16;
  localparam int GIDX_W = $clog2(GROUPS);
  // counts that saturate one past the group total
  localparam int GCNT_W = $clog2(GROUPS + 2);
  localparam int DCNT_W = $clog2(GROUP_DIGITS_MAX + 2);

  localparam logic [7:0] CHAR_COLON = 8'h3a;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_EMPTY       = 4'd1,
    ST_LONG        = 4'd2,
    ST_MULTI_SHORT = 4'd3,
    ST_EMPTY_GROUP = 4'd4,
    ST_TRAIL_COLON = 4'd5,
    ST_MANY        = 4'd6,
    ST_NOT_EIGHT   = 4'd7,
    ST_FULL_SHORT  = 4'd8,
    ST_BAD_GROUP   = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    SPLIT_NONE  = 2'd0,
    SPLIT_EMPTY = 2'd1,
    SPLIT_TRAIL = 2'd2
  } split_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h41 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: src/ip6tp_scan.sv
`timescale 1ns / 1ps
module ip6tp_scan import ip6tp_pkg::*; #(
  parameter int MAX_TEXT_LEN = DEFAULT_MAX_TEXT_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic        kind,
  input  logic [7:0]  char_code,
  output logic [3:0]  status,
  output logic [63:0] addr_high,
  output logic [63:0] addr_low
);

  localparam int CC_W = $clog2(MAX_TEXT_LEN + 2);
  localparam logic [CC_W-1:0] MAX_LEN = CC_W'(MAX_TEXT_LEN);

  logic [CC_W-1:0]   char_count, char_count_next;
  logic              prev_was_colon, prev_was_colon_next;
  logic              pair_closed, pair_closed_next;
  logic [1:0]        shorthand_count, shorthand_count_next;
  logic [DCNT_W-1:0] group_digits, group_digits_next;
  logic [GROUP_W-1:0] group_value, group_value_next;
  split_t            split_error, split_error_next;
  logic              bad_group_seen, bad_group_seen_next;
  logic [GCNT_W-1:0] head_count, head_count_next;
  logic [GCNT_W-1:0] tail_count, tail_count_next;
  logic [GROUP_W-1:0] head_groups [GROUPS];
  logic [GROUP_W-1:0] tail_groups [GROUPS];

  logic               push_en;
  logic               push_head;
  logic               push_tail;
  logic [DCNT_W-1:0]  gd_base;
  logic [GROUP_W-1:0] gv_base;
  hex_t               hex;
  logic [GROUP_W-1:0] head_eff [GROUPS];
  logic [GROUP_W-1:0] tail_eff [GROUPS];
  logic [GCNT_W:0]    total;
  status_t            st;
  logic [GROUP_W-1:0] grp [GROUPS];

  // state update for one character, plus the group push that an end item may do
  always_comb begin
    char_count_next = char_count;
    prev_was_colon_next = prev_was_colon;
    pair_closed_next = pair_closed;
    shorthand_count_next = shorthand_count;
    group_digits_next = group_digits;
    group_value_next = group_value;
    split_error_next = split_error;
    bad_group_seen_next = bad_group_seen;
    push_en = 1'b0;
    gd_base = group_digits;
    gv_base = group_value;
    hex = hex_decode(char_code);

    if (kind == KIND_CHAR) begin
      if (char_count <= MAX_LEN) char_count_next = char_count + CC_W'(1);
      if (char_code == CHAR_COLON) begin
        if (prev_was_colon) begin
          if (shorthand_count == 2'd0) begin
            push_en = (group_digits != '0);
            shorthand_count_next = 2'd1;
            group_digits_next = '0;
            group_value_next = '0;
          end else begin
            shorthand_count_next = 2'd2;
          end
          pair_closed_next = 1'b1;
        end else begin
          pair_closed_next = 1'b0;
        end
        prev_was_colon_next = 1'b1;
      end else begin
        // a lone colon before this character was a plain separator
        if (prev_was_colon && !pair_closed) begin
          if (group_digits == '0) begin
            if (split_error == SPLIT_NONE) split_error_next = SPLIT_EMPTY;
          end else begin
            push_en = 1'b1;
            gd_base = '0;
            gv_base = '0;
          end
        end
        prev_was_colon_next = 1'b0;
        pair_closed_next = 1'b0;
        if (!hex.ok || gd_base >= DCNT_W'(GROUP_DIGITS_MAX)) bad_group_seen_next = 1'b1;
        group_value_next = gv_base;
        if (hex.ok && gd_base < DCNT_W'(GROUP_DIGITS_MAX)) begin
          group_value_next = {gv_base[GROUP_W-5:0], hex.value};
        end
        group_digits_next = gd_base;
        if (gd_base <= DCNT_W'(GROUP_DIGITS_MAX)) group_digits_next = gd_base + DCNT_W'(1);
      end
    end else begin
      // close the last part of the text
      if (prev_was_colon) begin
        if (!pair_closed) begin
          if (group_digits == '0) begin
            if (split_error == SPLIT_NONE) split_error_next = SPLIT_EMPTY;
          end else begin
            push_en = 1'b1;
            if (split_error == SPLIT_NONE) split_error_next = SPLIT_TRAIL;
          end
        end
      end else if (char_count != '0) begin
        push_en = 1'b1;
      end
    end

    push_head = push_en && (shorthand_count == 2'd0);
    push_tail = push_en && (shorthand_count != 2'd0);
    head_count_next = head_count;
    tail_count_next = tail_count;
    if (push_head && head_count <= GCNT_W'(GROUPS)) head_count_next = head_count + GCNT_W'(1);
    if (push_tail && tail_count <= GCNT_W'(GROUPS)) tail_count_next = tail_count + GCNT_W'(1);
  end

  // group stores as they stand after this push; the tail store shifts in at the bottom
  always_comb begin
    for (int i = 0; i < GROUPS; i++) begin
      head_eff[i] = head_groups[i];
      if (push_head && head_count == GCNT_W'(i)) head_eff[i] = group_value;
      if (push_tail) begin
        tail_eff[i] = (i == GROUPS - 1) ? group_value : tail_groups[(i + 1) % GROUPS];
      end else begin
        tail_eff[i] = tail_groups[i];
      end
    end
  end

  always_comb begin
    total = {1'b0, head_count_next} + {1'b0, tail_count_next};
    priority if (char_count == '0) st = ST_EMPTY;
    else if (char_count > MAX_LEN) st = ST_LONG;
    else if (shorthand_count >= 2'd2) st = ST_MULTI_SHORT;
    else if (split_error_next == SPLIT_EMPTY) st = ST_EMPTY_GROUP;
    else if (split_error_next == SPLIT_TRAIL) st = ST_TRAIL_COLON;
    else if (total > (GCNT_W+1)'(GROUPS)) st = ST_MANY;
    else if (shorthand_count == 2'd0 && total != (GCNT_W+1)'(GROUPS)) st = ST_NOT_EIGHT;
    else if (shorthand_count == 2'd1 && total == (GCNT_W+1)'(GROUPS)) st = ST_FULL_SHORT;
    else if (bad_group_seen) st = ST_BAD_GROUP;
    else st = ST_OK;

    for (int p = 0; p < GROUPS; p++) begin
      if ({1'b0, tail_count_next} + (GCNT_W+1)'(p) >= (GCNT_W+1)'(GROUPS)) begin
        grp[p] = tail_eff[p];
      end else if (head_count_next > GCNT_W'(p)) begin
        grp[p] = head_eff[p];
      end else begin
        grp[p] = '0;
      end
      if (st != ST_OK) grp[p] = '0;
    end
  end

  assign status = st;
  assign addr_high = {grp[0], grp[1], grp[2], grp[3]};
  assign addr_low = {grp[4], grp[5], grp[6], grp[7]};

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      prev_was_colon <= 1'b0;
      pair_closed <= 1'b0;
      shorthand_count <= 2'd0;
      group_digits <= '0;
      group_value <= '0;
      split_error <= SPLIT_NONE;
      bad_group_seen <= 1'b0;
      head_count <= '0;
      tail_count <= '0;
    end else if (take) begin
      if (kind == KIND_END) begin
        char_count <= '0;
        prev_was_colon <= 1'b0;
        pair_closed <= 1'b0;
        shorthand_count <= 2'd0;
        group_digits <= '0;
        group_value <= '0;
        split_error <= SPLIT_NONE;
        bad_group_seen <= 1'b0;
        head_count <= '0;
        tail_count <= '0;
      end else begin
        char_count <= char_count_next;
        prev_was_colon <= prev_was_colon_next;
        pair_closed <= pair_closed_next;
        shorthand_count <= shorthand_count_next;
        group_digits <= group_digits_next;
        group_value <= group_value_next;
        split_error <= split_error_next;
        bad_group_seen <= bad_group_seen_next;
        head_count <= head_count_next;
        tail_count <= tail_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && kind == KIND_CHAR) begin
      for (int i = 0; i < GROUPS; i++) begin
        head_groups[i] <= head_eff[i];
        tail_groups[i] <= tail_eff[i];
      end
    end
  end

endmodule

FILE: src/ipv6_text_address_parser_top.sv
`timescale 1ns / 1ps
// IPv6 text address parser.
// Input channel (in_valid / in_stall): one item per transfer; kind 0 carries
// one ASCII character in char_code, kind 1 marks the end of the text.
// Output channel (out_valid / out_stall): one result per end item with the
// status code and the 128-bit address split into addr_high / addr_low; the
// address is zero unless the status is ok. Character items give no result.
// Throughput: one item per cycle, unless an end item waits for the result register;
// the character update between the input register and the parse state is
// combinational. An end item passes through the input register and then loads
// the result register.
// Character items keep flowing while a result waits; an end item waits in
// the input register until the result register is free, and in_stall rises
// only then. While out_stall is high the result holds steady.
// Reset clears the parse state and both valid flags.
module ipv6_text_address_parser_top import ip6tp_pkg::*; #(
  parameter int MAX_TEXT_LEN = DEFAULT_MAX_TEXT_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [63:0] addr_high,
  output logic [63:0] addr_low
);

  logic        ir_valid;
  logic        ir_kind;
  logic [7:0]  ir_char;
  logic        ir_go;
  logic        in_take;
  logic [3:0]  res_status;
  logic [63:0] res_high;
  logic [63:0] res_low;

  // an end item needs a free result register, a character never waits
  assign ir_go = ir_valid && (ir_kind == KIND_CHAR || !out_valid || !out_stall);
  assign in_stall = ir_valid && !ir_go;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else begin
      ir_valid <= in_take || (ir_valid && !ir_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ir_kind <= kind;
      ir_char <= char_code;
    end
  end

  ip6tp_scan #(
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .take(ir_go),
    .kind(ir_kind),
    .char_code(ir_char),
    .status(res_status),
    .addr_high(res_high),
    .addr_low(res_low)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ir_go && ir_kind == KIND_END) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ir_go && ir_kind == KIND_END) begin
      status <= res_status;
      addr_high <= res_high;
      addr_low <= res_low;
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ip6tp_pkg::*;

  localparam int MAX_LEN = DEFAULT_MAX_TEXT_LEN;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    status_t     st;
    logic [63:0] hi;
    logic [63:0] lo;
  } addr_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = KIND_CHAR;
  logic [7:0]  char_code = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  status;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  ipv6_text_address_parser_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .addr_high (addr_high),
    .addr_low  (addr_low)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // parser state mirror
  logic [6:0]  char_cnt;
  logic        prev_colon;
  logic [1:0]  short_cnt;
  logic [2:0]  dig_cnt;
  logic [15:0] grp_val;
  split_t      split_err;
  logic        bad_grp;
  logic [3:0]  head_cnt;
  logic [3:0]  tail_cnt;
  logic [15:0] head_vals [GROUPS];
  logic [15:0] tail_vals [GROUPS];
  logic        pair_done;

  addr_result_t pending_addrs[$];
  logic [7:0]   text_buf[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;
  int mismatches = 0;
  int cycle_cnt = 0;

  task automatic put_char(logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endtask

  task automatic clear_parser();
    char_cnt = '0;
    prev_colon = 1'b0;
    short_cnt = '0;
    dig_cnt = '0;
    grp_val = '0;
    split_err = SPLIT_NONE;
    bad_grp = 1'b0;
    head_cnt = '0;
    tail_cnt = '0;
    pair_done = 1'b0;
    for (int i = 0; i < GROUPS; i++) begin
      head_vals[i] = '0;
      tail_vals[i] = '0;
    end
  endtask

  function automatic int hex_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  task automatic close_group();
    if (short_cnt == 0) begin
      if (head_cnt < GROUPS) head_vals[head_cnt[2:0]] = grp_val;
      if (head_cnt <= GROUPS) head_cnt++;
    end else begin
      if (tail_cnt < GROUPS) tail_vals[tail_cnt[2:0]] = grp_val;
      if (tail_cnt <= GROUPS) tail_cnt++;
    end
    dig_cnt = '0;
    grp_val = '0;
  endtask

  task automatic note_split(split_t code);
    if (split_err == SPLIT_NONE) split_err = code;
  endtask

  task automatic parse_char(logic [7:0] c);
    int h;
    if (char_cnt <= MAX_LEN) char_cnt++;
    if (c == CHAR_COLON) begin
      if (prev_colon) begin
        if (short_cnt == 0) begin
          if (dig_cnt > 0) close_group();
          short_cnt = 2'd1;
          dig_cnt = '0;
          grp_val = '0;
        end else begin
          short_cnt = 2'd2;
        end
        pair_done = 1'b1;
      end else begin
        pair_done = 1'b0;
      end
      prev_colon = 1'b1;
    end else begin
      // a lone colon before this char was a plain separator
      if (prev_colon && !pair_done) begin
        if (dig_cnt == 0) note_split(SPLIT_EMPTY);
        else close_group();
      end
      prev_colon = 1'b0;
      pair_done = 1'b0;
      h = hex_val(c);
      if (h < 0 || dig_cnt >= GROUP_DIGITS_MAX) bad_grp = 1'b1;
      if (h >= 0 && dig_cnt < GROUP_DIGITS_MAX) grp_val = {grp_val[11:0], 4'(h)};
      if (dig_cnt <= GROUP_DIGITS_MAX) dig_cnt++;
    end
  endtask

  task automatic finish_address(output addr_result_t r);
    logic [15:0] g [GROUPS];
    int total;
    if (prev_colon) begin
      if (!pair_done) begin
        if (dig_cnt == 0) begin
          note_split(SPLIT_EMPTY);
        end else begin
          close_group();
          note_split(SPLIT_TRAIL);
        end
      end
    end else if (char_cnt > 0) begin
      close_group();
    end
    total = int'(head_cnt) + int'(tail_cnt);
    if (char_cnt == 0) r.st = ST_EMPTY;
    else if (char_cnt > MAX_LEN) r.st = ST_LONG;
    else if (short_cnt >= 2) r.st = ST_MULTI_SHORT;
    else if (split_err == SPLIT_EMPTY) r.st = ST_EMPTY_GROUP;
    else if (split_err == SPLIT_TRAIL) r.st = ST_TRAIL_COLON;
    else if (total > GROUPS) r.st = ST_MANY;
    else if (short_cnt == 0 && total != GROUPS) r.st = ST_NOT_EIGHT;
    else if (short_cnt == 1 && total == GROUPS) r.st = ST_FULL_SHORT;
    else if (bad_grp) r.st = ST_BAD_GROUP;
    else r.st = ST_OK;
    r.hi = '0;
    r.lo = '0;
    if (r.st == ST_OK) begin
      for (int i = 0; i < GROUPS; i++) g[i] = '0;
      for (int i = 0; i < int'(head_cnt); i++) g[i] = head_vals[i];
      // groups after the shorthand fill the bottom
      for (int i = 0; i < int'(tail_cnt); i++)
        g[(GROUPS - int'(tail_cnt) + i) & (GROUPS - 1)] = tail_vals[i];
      r.hi = {g[0], g[1], g[2], g[3]};
      r.lo = {g[4], g[5], g[6], g[7]};
    end
    clear_parser();
  endtask

  // one transfer on the input channel, prediction on acceptance
  task automatic send_item(logic k, logic [7:0] c);
    addr_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == KIND_CHAR) begin
      parse_char(c);
    end else begin
      finish_address(r);
      pending_addrs.insert(pending_addrs.size(), r);
    end
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_item(KIND_CHAR, text_buf[i]);
    send_item(KIND_END, 8'($urandom_range(255)));
  endtask

  task automatic send_str(string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
    send_text();
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 10) return 8'h30 + 8'(v);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  task automatic add_group();
    int n;
    logic [15:0] v;
    n = $urandom_range(1, 4);
    case ($urandom_range(3))
      0: v = 16'h0000;
      1: v = 16'hffff;
      default: v = 16'($urandom);
    endcase
    for (int i = n - 1; i >= 0; i--) put_char(hex_char(v[i*4 +: 4]));
  endtask

  task automatic make_valid_text();
    int heads;
    int tails;
    text_buf.delete();
    if ($urandom_range(2) == 0) begin
      for (int i = 0; i < GROUPS; i++) begin
        if (i > 0) put_char(CHAR_COLON);
        add_group();
      end
    end else begin
      heads = $urandom_range(0, GROUPS - 1);
      tails = $urandom_range(0, GROUPS - 1 - heads);
      for (int i = 0; i < heads; i++) begin
        if (i > 0) put_char(CHAR_COLON);
        add_group();
      end
      put_char(CHAR_COLON);
      put_char(CHAR_COLON);
      for (int i = 0; i < tails; i++) begin
        if (i > 0) put_char(CHAR_COLON);
        add_group();
      end
    end
  endtask

  function automatic logic [7:0] noise_char();
    case ($urandom_range(3))
      0: return CHAR_COLON;
      1: return hex_char(4'($urandom));
      2: return 8'h67;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic make_random_text();
    int sel;
    int pos;
    int len;
    sel = $urandom_range(99);
    if (sel < 70) begin
      make_valid_text();
    end else if (sel < 85) begin
      make_valid_text();
      pos = $urandom_range(text_buf.size() - 1);
      case ($urandom_range(4))
        0: text_buf[pos] = 8'($urandom_range(255));
        1: text_buf.insert(pos, CHAR_COLON);
        2: text_buf.delete(pos);
        3: begin
          put_char(CHAR_COLON);
          add_group();
        end
        default: text_buf.insert(pos, hex_char(4'($urandom)));
      endcase
    end else if (sel < 93) begin
      text_buf.delete();
      len = $urandom_range(1, 12);
      repeat (len) put_char(noise_char());
    end else if (sel < 97) begin
      // around the length limit
      text_buf.delete();
      len = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
      repeat (len)
        put_char(($urandom_range(4) == 0) ? CHAR_COLON : hex_char(4'($urandom)));
    end else begin
      text_buf.delete();
    end
  endtask

  task automatic run_random(int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) begin
      make_random_text();
      send_text();
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 30;
    stall_pct = 30;
    send_str("");
    send_str("::");
    send_str("1:2:3:4:5:6:7:8");
    send_str("ffff:FFFF:0:0:0:0:aBcD:9");
    send_str("::1");
    send_str("fe80::");
    send_str("1::2::3");
    send_str(":::");
    send_str("1:::2");
    send_str(":");
    send_str(":1:2:3:4:5:6:7");
    send_str("1:2::3:");
    send_str("1:2:3:4:5:6:7:");
    send_str(":1:");
    send_str("1::2:3:4:5:6:7:8");
    send_str("1:2:3:4:5:6:7:8:9");
    send_str("1::2:3:4:5:6:7:8:9");
    send_str("1:2:3");
    send_str("12345::");
    send_str("1:g::");
    // non-printing and top codes inside a group
    send_str("1:2:3:4:5:6:7:8");
    text_buf[2] = 8'h00;
    send_text();
    text_buf[4] = 8'hff;
    send_text();
    text_buf.delete();
    repeat (MAX_LEN) put_char(8'h31);
    send_text();
    put_char(8'h31);
    send_text();
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    run_random(120);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 77;
    stall_pct = 0;
    run_random(120);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    stall_pct = 77;
    run_random(120);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 18;
    stall_pct = 18;
    run_random(120);
  endtask

  // long output hold-off while short texts keep arriving
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 100;
    repeat (10) send_str("::");
    send_str("1:2:3:4:5:6:7:8");
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    addr_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_addrs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d high %h low %h", status, addr_high, addr_low);
      end else begin
        exp_r = pending_addrs.pop_front();
        if (status !== exp_r.st || addr_high !== exp_r.hi || addr_low !== exp_r.lo) begin
          mismatches++;
          if (mismatches <= 10) begin
            if (status !== exp_r.st)
              $display("status mismatch: expected %0d (%s) got %0d",
                       exp_r.st, exp_r.st.name(), status);
            if (addr_high !== exp_r.hi)
              $display("addr_high mismatch: expected %h got %h", exp_r.hi, addr_high);
            if (addr_low !== exp_r.lo)
              $display("addr_low mismatch: expected %h got %h", exp_r.lo, addr_low);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_addrs.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_backpressure();
    in_valid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
